/* design/rgcd_pkg.sv */
// Shared types, widths and state codes for the rational arithmetic reducer.
package rgcd_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int SUM_W         = PROD_W + 1;
    localparam int MAG_W         = 2 * OPERAND_WIDTH;
    localparam int NUM_W         = 33;
    localparam int DEN_W         = 31;
    localparam int CNT_W         = $clog2(MAG_W + 1);

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                           mode;
        logic signed [OPERAND_WIDTH-1:0] left_num;
        logic signed [OPERAND_WIDTH-1:0] left_den;
        logic signed [OPERAND_WIDTH-1:0] right_num;
        logic signed [OPERAND_WIDTH-1:0] right_den;
    } t_in_item;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_num;
        logic        [DEN_W-1:0] result_den;
        logic                    is_whole;
        logic                    bad_denominator;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
        logic [MAG_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_SIGN,
        ST_GCD_GO,
        ST_GCD_WAIT,
        ST_DIVN_GO,
        ST_DIVN_WAIT,
        ST_DIVD_GO,
        ST_DIVD_WAIT,
        ST_FINISH
    } t_state;

endpackage

/* design/rgcd_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module rgcd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rgcd_pkg::t_div_req i_req,
    output rgcd_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [rgcd_pkg::CNT_W-1:0]    r_cnt;
    logic [rgcd_pkg::MAG_W:0]      r_rem;
    logic [rgcd_pkg::MAG_W-1:0]    r_quo;
    logic [rgcd_pkg::MAG_W-1:0]    r_dsr;

    logic [rgcd_pkg::MAG_W:0]      shifted;
    logic                          take;

    always_comb begin
        shifted = {r_rem[rgcd_pkg::MAG_W-1:0], r_quo[rgcd_pkg::MAG_W-1]};
        take    = (shifted >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= rgcd_pkg::CNT_W'(rgcd_pkg::MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - rgcd_pkg::CNT_W'(1);
                if (r_cnt == rgcd_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= take ? (shifted - {1'b0, r_dsr}) : shifted;
            r_quo <= {r_quo[rgcd_pkg::MAG_W-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[rgcd_pkg::MAG_W-1:0];

endmodule

/* design/rational_arith_gcd_reduce.sv */
// Rational add, subtract, multiply and divide with GCD reduction.
//
// Takes one item (mode and two fractions), forms the cross products through a single
// shared signed multiplier over the states ST_MUL1 to ST_MUL4, moves the sign onto the
// numerator and reduces both parts by a Euclidean GCD whose remainders, and the two
// final exact divisions, all run on one bit-serial divider. An item with a zero
// result denominator skips the reduction and finishes with the flag set. The block
// takes one item at a time; the finished result sits in an output register, so a new
// item is taken while the previous result still waits.
module rational_arith_gcd_reduce (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rgcd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rgcd_pkg::t_out_item o_out_data
);

    localparam int W = rgcd_pkg::OPERAND_WIDTH;

    rgcd_pkg::t_state    r_state, n_state;
    rgcd_pkg::t_in_item  r_item;
    rgcd_pkg::t_out_item r_out;
    logic                r_out_vld;

    logic signed [rgcd_pkg::PROD_W-1:0] r_prod;
    logic signed [rgcd_pkg::SUM_W-1:0]  r_e;
    logic signed [rgcd_pkg::PROD_W-1:0] r_f;
    logic [rgcd_pkg::MAG_W-1:0]         r_nm, r_dm, r_ga, r_gb;
    logic                               r_neg;

    logic signed [W-1:0]                mul_x, mul_y;
    logic signed [rgcd_pkg::PROD_W-1:0] mul_p;
    logic signed [rgcd_pkg::SUM_W-1:0]  e_abs;
    logic signed [rgcd_pkg::PROD_W-1:0] f_abs;
    logic signed [rgcd_pkg::MAG_W:0]    num_s;
    logic                               f_zero;
    logic                               out_free;

    rgcd_pkg::t_div_req div_req;
    rgcd_pkg::t_div_rsp div_rsp;

    rgcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mul_p    = mul_x * mul_y;
    assign f_zero   = (r_f == '0);
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        e_abs = r_e[rgcd_pkg::SUM_W-1] ? -r_e : r_e;
        f_abs = r_f[rgcd_pkg::PROD_W-1] ? -r_f : r_f;
        num_s = r_neg ? -$signed({1'b0, r_nm}) : $signed({1'b0, r_nm});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        mul_x            = r_item.left_num;
        mul_y            = r_item.right_den;
        div_req.start    = 1'b0;
        div_req.dividend = r_ga;
        div_req.divisor  = r_gb;
        unique case (r_state)
            rgcd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = rgcd_pkg::ST_MUL1;
            end
            rgcd_pkg::ST_MUL1: begin
                if (r_item.mode == rgcd_pkg::MODE_MUL) mul_y = r_item.right_num;
                n_state = rgcd_pkg::ST_MUL2;
            end
            rgcd_pkg::ST_MUL2: begin
                mul_x   = r_item.right_num;
                mul_y   = r_item.left_den;
                n_state = rgcd_pkg::ST_MUL3;
            end
            rgcd_pkg::ST_MUL3: begin
                mul_x = r_item.left_den;
                if (r_item.mode == rgcd_pkg::MODE_DIV) mul_y = r_item.right_num;
                n_state = rgcd_pkg::ST_MUL4;
            end
            rgcd_pkg::ST_MUL4: begin
                n_state = rgcd_pkg::ST_SIGN;
            end
            rgcd_pkg::ST_SIGN: begin
                n_state = f_zero ? rgcd_pkg::ST_FINISH : rgcd_pkg::ST_GCD_GO;
            end
            rgcd_pkg::ST_GCD_GO: begin
                if (r_gb == '0) begin
                    n_state = rgcd_pkg::ST_DIVN_GO;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = rgcd_pkg::ST_GCD_WAIT;
                end
            end
            rgcd_pkg::ST_GCD_WAIT: begin
                if (div_rsp.done) n_state = rgcd_pkg::ST_GCD_GO;
            end
            rgcd_pkg::ST_DIVN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_nm;
                div_req.divisor  = r_ga;
                n_state          = rgcd_pkg::ST_DIVN_WAIT;
            end
            rgcd_pkg::ST_DIVN_WAIT: begin
                if (div_rsp.done) n_state = rgcd_pkg::ST_DIVD_GO;
            end
            rgcd_pkg::ST_DIVD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_dm;
                div_req.divisor  = r_ga;
                n_state          = rgcd_pkg::ST_DIVD_WAIT;
            end
            rgcd_pkg::ST_DIVD_WAIT: begin
                if (div_rsp.done) n_state = rgcd_pkg::ST_FINISH;
            end
            rgcd_pkg::ST_FINISH: begin
                if (out_free) n_state = rgcd_pkg::ST_IDLE;
            end
            default: begin
                n_state = rgcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath: products, sign handling, Euclid operands and quotients
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rgcd_pkg::ST_IDLE: begin
                if (i_in_valid) r_item <= i_in_data;
            end
            rgcd_pkg::ST_MUL1: begin
                r_prod <= mul_p;
            end
            rgcd_pkg::ST_MUL2: begin
                r_e    <= rgcd_pkg::SUM_W'(r_prod);
                r_prod <= mul_p;
            end
            rgcd_pkg::ST_MUL3: begin
                if (r_item.mode == rgcd_pkg::MODE_ADD) begin
                    r_e <= r_e + rgcd_pkg::SUM_W'(r_prod);
                end else if (r_item.mode == rgcd_pkg::MODE_SUB) begin
                    r_e <= r_e - rgcd_pkg::SUM_W'(r_prod);
                end
                r_prod <= mul_p;
            end
            rgcd_pkg::ST_MUL4: begin
                r_f <= r_prod;
            end
            rgcd_pkg::ST_SIGN: begin
                r_neg <= r_e[rgcd_pkg::SUM_W-1] ^ r_f[rgcd_pkg::PROD_W-1];
                r_nm  <= rgcd_pkg::MAG_W'($unsigned(e_abs));
                r_dm  <= rgcd_pkg::MAG_W'($unsigned(f_abs));
                r_ga  <= rgcd_pkg::MAG_W'($unsigned(e_abs));
                r_gb  <= rgcd_pkg::MAG_W'($unsigned(f_abs));
            end
            rgcd_pkg::ST_GCD_WAIT: begin
                if (div_rsp.done) begin
                    r_ga <= r_gb;
                    r_gb <= div_rsp.rem;
                end
            end
            rgcd_pkg::ST_DIVN_WAIT: begin
                if (div_rsp.done) r_nm <= div_rsp.quot;
            end
            rgcd_pkg::ST_DIVD_WAIT: begin
                if (div_rsp.done) r_dm <= div_rsp.quot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == rgcd_pkg::ST_FINISH && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Load the result item; a zero denominator gives all-zero fields with the flag
    always_ff @(posedge i_clk) begin
        if (r_state == rgcd_pkg::ST_FINISH && out_free) begin
            if (f_zero) begin
                r_out.result_num      <= '0;
                r_out.result_den      <= '0;
                r_out.is_whole        <= 1'b0;
                r_out.bad_denominator <= 1'b1;
            end else begin
                r_out.result_num      <= rgcd_pkg::NUM_W'(num_s);
                r_out.result_den      <= rgcd_pkg::DEN_W'(r_dm);
                r_out.is_whole        <= (r_dm == rgcd_pkg::MAG_W'(1));
                r_out.bad_denominator <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == rgcd_pkg::ST_GCD_WAIT ||
                          r_state == rgcd_pkg::ST_DIVN_WAIT ||
                          r_state == rgcd_pkg::ST_DIVD_WAIT))
        else $error("divider finished outside a wait state");

    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_rsp.done && (r_state == rgcd_pkg::ST_DIVN_WAIT ||
                          r_state == rgcd_pkg::ST_DIVD_WAIT)) |-> (div_rsp.rem == '0))
        else $error("reduction by gcd left a remainder");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.bad_denominator) |-> (o_out_data.result_den != '0))
        else $error("reduced denominator is zero");

    a_bad_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_denominator) |->
            (o_out_data.result_num == '0 && o_out_data.result_den == '0 &&
             !o_out_data.is_whole))
        else $error("flagged result carries nonzero fields");

    a_gcd_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.divisor != '0))
        else $error("divider started with a zero divisor");
`endif

endmodule
